/* design/lzc_pkg.sv */
// shared types and constants of the laplacian zero-crossing detector
package lzc_pkg;

    // register file layout
    localparam int unsigned LINE_WIDTH_W  = 11;
    localparam int unsigned THRESHOLD_W   = 31;
    localparam int unsigned APB_DATA_W    = 32;
    localparam int unsigned APB_ADDR_W    = 3;

    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = LINE_WIDTH_W'(640);
    localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RST  = '0;

    // register indexes, taken from paddr[2]
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_THRESHOLD  = 1'b1;

    // row store depth
    localparam int unsigned MAX_WIDTH_DEF = 1024;

    // payload widths
    localparam int unsigned LAP_W = 16;
    localparam int unsigned PIX_W = 8;
    localparam int unsigned PROD_W = 2 * LAP_W;

    // output pixel codes
    localparam logic [PIX_W-1:0] PIX_EDGE = 8'd0;
    localparam logic [PIX_W-1:0] PIX_FLAT = 8'd255;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [LINE_WIDTH_W-1:0] line_width;
        logic [THRESHOLD_W-1:0]  product_threshold;
    } cfg_t;

    // beat handed from the row-store stage to the evaluation stage
    typedef struct packed {
        logic                    valid;
        logic                    past;
        logic signed [LAP_W-1:0] cur;
        logic signed [LAP_W-1:0] prev;
        logic signed [LAP_W-1:0] above;
    } s1_t;

endpackage

/* design/lzc_if.sv */
// stream interfaces for laplacian values in and binary pixels out
interface lzc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lzc_pkg::LAP_W-1:0]      lap_value;
    logic                                  frame_start;

    modport source (output valid, output lap_value, output frame_start, input ready);
    modport sink   (input valid, input lap_value, input frame_start, output ready);
endinterface

interface lzc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [lzc_pkg::PIX_W-1:0]             pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

/* design/lzc_cfg.sv */
// apb register file holding line width and product threshold
module lzc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lzc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lzc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lzc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output lzc_pkg::cfg_t                     cfg
);
    import lzc_pkg::*;

    logic [LINE_WIDTH_W-1:0] line_width_reg;
    logic [THRESHOLD_W-1:0]  threshold_reg;
    logic                    reg_sel;
    logic                    wr_en;

    // zero wait states
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RST;
            threshold_reg  <= THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_LINE_WIDTH: line_width_reg <= pwdata[LINE_WIDTH_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= pwdata[THRESHOLD_W-1:0];
                default:        ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_sel)
            REG_LINE_WIDTH: prdata = APB_DATA_W'(line_width_reg);
            REG_THRESHOLD:  prdata = APB_DATA_W'(threshold_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.line_width        = line_width_reg;
    assign cfg.product_threshold = threshold_reg;

endmodule

/* design/lzc_front.sv */
// column tracking and row-above store with read-then-write per beat
module lzc_front #(
    parameter int unsigned MAX_WIDTH = lzc_pkg::MAX_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lzc_pkg::cfg_t  cfg,
    lzc_in_if.sink         pix_in,
    output lzc_pkg::s1_t   s1,
    input  logic           s1_ready
);
    import lzc_pkg::*;

    localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned EW    = (CNT_W > LINE_WIDTH_W) ? CNT_W : LINE_WIDTH_W;

    logic [COL_W-1:0]        col_reg, col_next;
    logic                    past_reg, past_next;
    logic signed [LAP_W-1:0] prev_reg;

    logic                    s1_valid_reg, s1_valid_next;
    logic                    s1_past_reg;
    logic signed [LAP_W-1:0] s1_cur_reg;
    logic signed [LAP_W-1:0] s1_prev_reg;
    logic signed [LAP_W-1:0] rd_data_reg;

    logic signed [LAP_W-1:0] row_mem [MAX_WIDTH];

    logic             accept;
    logic [COL_W-1:0] col_cur;
    logic             past_cur;
    logic [EW-1:0]    lw_ext;
    logic [EW-1:0]    w_eff;
    logic [EW-1:0]    col_plus;

    // stage one frees up when it is empty or its beat moves on
    assign pix_in.ready = !s1_valid_reg || s1_ready;
    assign accept       = pix_in.valid && pix_in.ready;

    // clamp the configured width to the supported range
    assign lw_ext = EW'(cfg.line_width);
    always_comb
    begin
        if (lw_ext < EW'(2))
            w_eff = EW'(2);
        else if (lw_ext > EW'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = lw_ext;
    end

    // frame start restarts the first row at column zero
    assign col_cur  = pix_in.frame_start ? '0 : col_reg;
    assign past_cur = pix_in.frame_start ? 1'b0 : past_reg;
    assign col_plus = EW'(col_cur) + EW'(1);

    // column counter and row flag
    always_comb
    begin
        col_next      = col_reg;
        past_next     = past_reg;
        s1_valid_next = s1_valid_reg;
        if (s1_valid_reg && s1_ready)
            s1_valid_next = 1'b0;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            if (col_plus >= w_eff)
            begin
                col_next  = '0;
                past_next = 1'b1;
            end
            else
            begin
                col_next  = col_plus[COL_W-1:0];
                past_next = past_cur;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            past_reg     <= 1'b0;
            prev_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            past_reg     <= past_next;
            s1_valid_reg <= s1_valid_next;
            if (accept)
                prev_reg <= pix_in.lap_value;
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg  <= pix_in.lap_value;
            s1_prev_reg <= prev_reg;
            s1_past_reg <= past_cur;
        end
    end

    // row store: old entry read out, current value written to the same column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg      <= row_mem[col_cur];
            row_mem[col_cur] <= pix_in.lap_value;
        end
    end

    assign s1.valid = s1_valid_reg;
    assign s1.past  = s1_past_reg;
    assign s1.cur   = s1_cur_reg;
    assign s1.prev  = s1_prev_reg;
    assign s1.above = rd_data_reg;

    // column pointer never leaves the store
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(col_reg) < EW'(MAX_WIDTH))
        else $error("column pointer outside row store");

    // a frame start beat is always treated as first-row
    a_frame_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pix_in.frame_start |=> s1_valid_reg && !s1_past_reg)
        else $error("frame start beat not in first row");

    // a held stage keeps its operands and the row store data
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_ready |=>
            s1_valid_reg && $stable(s1_cur_reg) && $stable(rd_data_reg)
            && $stable(s1_prev_reg))
        else $error("stalled stage one lost its data");

endmodule

/* design/lzc_eval.sv */
// product stage, threshold compare and output register
module lzc_eval (
    input  logic           clk,
    input  logic           rst_n,
    input  lzc_pkg::cfg_t  cfg,
    input  lzc_pkg::s1_t   s1,
    output logic           s1_ready,
    lzc_out_if.source      pix_out
);
    import lzc_pkg::*;

    logic                     s2_valid_reg, s2_valid_next;
    logic                     s2_past_reg;
    logic signed [PROD_W-1:0] horiz_reg;
    logic signed [PROD_W-1:0] vert_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]         out_pixel_reg;

    logic                     s2_ready;
    logic                     out_free;
    logic                     s1_take;
    logic                     s2_take;
    logic signed [PROD_W:0]   limit;
    logic                     crossing;

    // ready chain from the output register back
    assign out_free = !out_valid_reg || pix_out.ready;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s1_ready = s2_ready;
    assign s1_take  = s1.valid && s2_ready;
    assign s2_take  = s2_valid_reg && out_free;

    // minus threshold, one bit wider than a product
    assign limit = -$signed({2'b00, cfg.product_threshold});

    // zero crossing when either product falls below the limit
    assign crossing = ($signed({horiz_reg[PROD_W-1], horiz_reg}) < limit)
                   || ($signed({vert_reg[PROD_W-1], vert_reg}) < limit);

    // valid tracking
    always_comb
    begin
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && pix_out.ready)
            out_valid_next = 1'b0;
        if (s2_take)
        begin
            out_valid_next = 1'b1;
            s2_valid_next  = 1'b0;
        end
        if (s1_take)
            s2_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // horizontal and vertical products
    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            horiz_reg   <= s1.cur * s1.prev;
            vert_reg    <= s1.cur * s1.above;
            s2_past_reg <= s1.past;
        end
    end

    // output pixel
    always_ff @(posedge clk)
    begin
        if (s2_take)
            out_pixel_reg <= (s2_past_reg && crossing) ? PIX_EDGE : PIX_FLAT;
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.pixel_out = out_pixel_reg;

    // only the two binary levels ever leave
    a_binary_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pixel_reg == PIX_EDGE) || (out_pixel_reg == PIX_FLAT))
        else $error("output pixel not binary");

    // first-row beats come out flat
    a_first_row_flat: assert property (@(posedge clk) disable iff (!rst_n)
        s2_take && !s2_past_reg |=> out_valid_reg && (out_pixel_reg == PIX_FLAT))
        else $error("first-row pixel marked as edge");

    // a held product stage keeps its products
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_free |=>
            s2_valid_reg && $stable(horiz_reg) && $stable(vert_reg))
        else $error("stalled product stage lost its data");

endmodule

/* design/laplacian_zero_crossing_detector.sv */
// top level of the laplacian zero-crossing edge detector
//
// pix_in carries one signed 16-bit laplacian value per beat in raster order,
// with frame_start set on the first pixel of a frame; pix_out returns one
// pixel per input beat, 0 at a zero crossing and 255 otherwise, first row
// always 255. both channels use valid/ready, a beat moves when both are high.
// the apb port holds line_width at address 0 and product_threshold at 4;
// write them only while no beat is in flight.
// a taken beat passes the stage-one, product and result registers in order.
// throughput is one beat per cycle while pix_out does not stall, set by
// the row store: each beat does one read and one write of its column in the
// same cycle.
// reset: line_width 640, threshold 0, the stream starts as a new frame. the
// row store has no reset; the first row of each frame fills it before use.
// when pix_out stalls, the result register holds and the two stages behind it
// keep taking beats until full, then pix_in.ready drops.
module laplacian_zero_crossing_detector #(
    parameter int unsigned MAX_WIDTH = lzc_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lzc_in_if.sink                            pix_in,
    lzc_out_if.source                         pix_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lzc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lzc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lzc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import lzc_pkg::*;

    cfg_t cfg;
    s1_t  s1;
    logic s1_ready;

    // configuration registers
    lzc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // column tracking and row store
    lzc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pix_in   (pix_in),
        .s1       (s1),
        .s1_ready (s1_ready)
    );

    // products, compare and result register
    lzc_eval u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s1       (s1),
        .s1_ready (s1_ready),
        .pix_out  (pix_out)
    );

endmodule
